### rtl/mfs_pkg.sv
// Shared types and constants of the metaball field splat block.
package mfs_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] REG_TILE_X    = 3'd0;
    localparam logic [2:0] REG_TILE_Y    = 3'd1;
    localparam logic [2:0] REG_TILE_Z    = 3'd2;
    localparam logic [2:0] REG_CUTOFF    = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    localparam logic [15:0] CUTOFF_RESET    = 16'd1408;
    localparam logic [31:0] THRESHOLD_RESET = 32'd32873;

    // Kernel pipeline depth, issue register to write-back register.
    localparam int PIPE_STAGES = 25;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [23:0] center_z;
        logic [15:0]        scale;
        logic [9:0]         corner_index;
    } t_req;

    typedef struct packed {
        logic [31:0] field_value;
        logic        inside_res;
        logic [9:0]  corners_added;
        logic        saturated;
    } t_rsp;

    typedef struct packed {
        logic take;      // latch the request, clear working results
        logic sweep_wr;  // write zero at the scan counter
        logic step;      // advance the corner counters
        logic issue;     // push the current corner into the kernel pipeline
        logic load_r;    // radius product
        logic load_r2;   // squared radius and per-axis origin
        logic rd_issue;  // read the store at the requested corner
        logic rd_cap;    // capture read data
        logic out_load;  // move working results to the output register
    } t_cmd;

    typedef struct packed {
        logic last;      // counter is at the final corner
        logic busy;      // kernel pipeline holds work
        logic r2_zero;   // zero radius
    } t_sts;

endpackage

### rtl/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 729
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/mfs_ctrl.sv
// Sequencer: request handshake, clear sweep, splat scan, read, result handoff.
module mfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic [1:0]    i_req_op,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  mfs_pkg::t_sts i_sts,
    output mfs_pkg::t_cmd o_cmd
);
    import mfs_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_MUL, S_SQR, S_SCAN, S_DRAIN, S_RD0, S_RD1, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_rep, n_rep;
    logic   r_out_v, n_out_v;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_rep   = r_rep;
        case (r_state)
            S_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                cmd.step     = 1'b1;
                if (i_sts.last) begin
                    n_state = r_rep ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.take = 1'b1;
                    case (i_req_op)
                        OP_CLEAR: begin
                            n_state = S_SWEEP;
                            n_rep   = 1'b1;
                        end
                        OP_SPLAT: n_state = S_MUL;
                        OP_READ:  n_state = S_RD0;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: begin
                cmd.load_r = 1'b1;
                n_state    = S_SQR;
            end
            S_SQR: begin
                cmd.load_r2 = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.r2_zero) begin
                    n_state = S_DONE;
                end else begin
                    cmd.step  = 1'b1;
                    cmd.issue = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_DONE;
                end
            end
            S_RD0: begin
                cmd.rd_issue = 1'b1;
                n_state      = S_RD1;
            end
            S_RD1: begin
                cmd.rd_cap = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || i_rsp_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_v = (r_out_v && !i_rsp_ready) || cmd.out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_rep   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rep   <= (r_state == S_SWEEP && i_sts.last) ? 1'b0 : n_rep;
            r_out_v <= n_out_v;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_v;
    assign o_cmd       = cmd;
endmodule

### rtl/mfs_dp.sv
// Datapath: config registers, corner counters, kernel pipeline, field store.
module mfs_dp #(
    parameter int TILE_EDGE_CELLS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  mfs_pkg::t_req i_req,
    input  mfs_pkg::t_cmd i_cmd,
    output mfs_pkg::t_sts o_sts,
    output mfs_pkg::t_rsp o_rsp
);
    import mfs_pkg::*;

    localparam int NC    = TILE_EDGE_CELLS + 1;
    localparam int NCORN = NC * NC * NC;
    localparam int CW    = $clog2(NCORN);
    localparam int IW    = $clog2(NC);
    localparam int NS    = PIPE_STAGES;

    function automatic logic [16:0] rmul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = a * b + 34'd32768;
        return p[32:16];
    endfunction

    function automatic logic signed [31:0] origin(input logic [15:0] tile,
                                                  input logic [23:0] c);
        logic signed [31:0] b;
        b = 32'(signed'(tile)) * 32'(TILE_EDGE_CELLS);
        return (b <<< 8) - 32'(signed'(c));
    endfunction

    // configuration
    logic [15:0] r_tx, r_ty, r_tz, r_cut;
    logic [31:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx  <= '0;
            r_ty  <= '0;
            r_tz  <= '0;
            r_cut <= CUTOFF_RESET;
            r_thr <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TILE_X:    r_tx  <= i_cfg_data[15:0];
                REG_TILE_Y:    r_ty  <= i_cfg_data[15:0];
                REG_TILE_Z:    r_tz  <= i_cfg_data[15:0];
                REG_CUTOFF:    r_cut <= i_cfg_data[15:0];
                REG_THRESHOLD: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // corner counters, x fastest
    logic [IW-1:0] r_ix, r_iy, r_iz;
    logic [CW-1:0] r_idx;
    logic          last;

    assign last = (r_idx == CW'(NCORN - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix  <= '0;
            r_iy  <= '0;
            r_iz  <= '0;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= last ? '0 : r_idx + 1'b1;
            if (r_ix == IW'(NC - 1)) begin
                r_ix <= '0;
                if (r_iy == IW'(NC - 1)) begin
                    r_iy <= '0;
                    r_iz <= (r_iz == IW'(NC - 1)) ? '0 : r_iz + 1'b1;
                end else begin
                    r_iy <= r_iy + 1'b1;
                end
            end else begin
                r_ix <= r_ix + 1'b1;
            end
        end
    end

    // request and splat setup
    t_req               r_item;
    logic [31:0]        r_rad;
    logic [63:0]        r_r2;
    logic signed [31:0] r_ox, r_oy, r_oz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_req;
        end
        if (i_cmd.load_r) begin
            r_rad <= r_cut * r_item.scale;
        end
        if (i_cmd.load_r2) begin
            r_r2 <= r_rad * r_rad;
            r_ox <= origin(r_tx, r_item.center_x);
            r_oy <= origin(r_ty, r_item.center_y);
            r_oz <= origin(r_tz, r_item.center_z);
        end
    end

    // kernel pipeline control
    logic          r_pv  [NS];
    logic          r_pok [NS];
    logic [CW-1:0] r_pidx[NS];
    logic          busy;

    always_comb begin
        busy = 1'b0;
        for (int s = 0; s < NS; s++) begin
            busy = busy | r_pv[s];
        end
    end

    // stage payloads
    logic signed [31:0] r_d [3];
    logic [19:0]        r_m [3];
    logic               r_far1, r_far2;
    logic [39:0]        r_sq[3];
    logic [63:0]        r_num;
    logic [63:0]        r_dr[16];
    logic [15:0]        r_dq[16];
    logic [16:0]        r_y2, r_y4, r_y8, r_y4c, r_k, r_kw;

    logic [31:0] mag [3];
    logic [2:0]  farv;
    logic [41:0] d2;
    logic        pass;
    logic [63:0] dv_r[16];
    logic [15:0] dv_q[16];
    logic [16:0] yq;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag[a]  = r_d[a][31] ? 32'(-r_d[a]) : 32'(r_d[a]);
            farv[a] = |mag[a][31:20];
        end
        d2   = 42'(r_sq[0]) + 42'(r_sq[1]) + 42'(r_sq[2]);
        pass = !r_far2 && (d2[41:40] == 2'b00) && ({d2[39:0], 24'd0} < r_r2);
        for (int j = 0; j < 16; j++) begin
            logic [63:0] src;
            logic [15:0] qs;
            logic [63:0] sh;
            src = (j == 0) ? r_num : r_dr[(j == 0) ? 0 : j - 1];
            qs  = (j == 0) ? 16'd0 : r_dq[(j == 0) ? 0 : j - 1];
            sh  = {src[62:0], 1'b0};
            if (src[63] || sh >= r_r2) begin
                dv_r[j] = sh - r_r2;
                dv_q[j] = {qs[14:0], 1'b1};
            end else begin
                dv_r[j] = sh;
                dv_q[j] = {qs[14:0], 1'b0};
            end
        end
        yq = 17'h10000 - {1'b0, r_dq[15]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_pv[s] <= 1'b0;
            end
        end else begin
            r_pv[0] <= i_cmd.issue;
            for (int s = 1; s < NS; s++) begin
                r_pv[s] <= r_pv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx[0] <= r_idx;
        r_pok[0]  <= 1'b0;
        // distance test result enters at stage 3
        for (int s = 1; s < NS; s++) begin
            r_pidx[s] <= r_pidx[s-1];
            r_pok[s]  <= (s == 3) ? pass : r_pok[s-1];
        end

        r_d[0] <= r_ox + (32'(r_ix) <<< 8);
        r_d[1] <= r_oy + (32'(r_iy) <<< 8);
        r_d[2] <= r_oz + (32'(r_iz) <<< 8);
        for (int a = 0; a < 3; a++) begin
            r_m[a]  <= mag[a][19:0];
            r_sq[a] <= r_m[a] * r_m[a];
        end
        r_far1 <= |farv;
        r_far2 <= r_far1;
        r_num  <= {d2[39:0], 24'd0};
        for (int j = 0; j < 16; j++) begin
            r_dr[j] <= dv_r[j];
            r_dq[j] <= dv_q[j];
        end
        r_y2  <= rmul(yq, yq);
        r_y4  <= rmul(r_y2, r_y2);
        r_y8  <= rmul(r_y4, r_y4);
        r_y4c <= r_y4;
        r_k   <= rmul(r_y8, r_y4c);
        r_kw  <= r_k;
    end

    // field store
    logic          we;
    logic [CW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic [32:0]   acc;
    logic          wb;
    logic          inr;

    assign wb    = r_pv[NS-1] && r_pok[NS-1];
    assign acc   = {1'b0, rdata} + 33'(r_kw);
    assign we    = i_cmd.sweep_wr || wb;
    assign waddr = i_cmd.sweep_wr ? r_idx : r_pidx[NS-1];
    assign wdata = i_cmd.sweep_wr ? 32'd0 : (acc[32] ? 32'hFFFF_FFFF : acc[31:0]);
    assign raddr = i_cmd.rd_issue ? CW'(r_item.corner_index) : r_pidx[NS-2];
    assign inr   = (32'(r_item.corner_index) < 32'(NCORN));

    mfs_ram #(
        .WIDTH(32),
        .DEPTH(NCORN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // working results and output register
    t_rsp r_work, r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_work <= '0;
        end else begin
            if (wb) begin
                r_work.corners_added <= r_work.corners_added + 1'b1;
                r_work.saturated     <= r_work.saturated | acc[32];
            end
            if (i_cmd.rd_cap) begin
                r_work.field_value <= inr ? rdata : 32'd0;
                r_work.inside_res  <= inr && (rdata > r_thr);
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_work;
        end
    end

    assign o_sts.last    = last;
    assign o_sts.busy    = busy;
    assign o_sts.r2_zero = (r_r2 == 64'd0);
    assign o_rsp         = r_out;
endmodule

### rtl/metaball_field_splat.sv
// Top level of the metaball field splat block: sequencer plus datapath.
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+------------------------------
//  request   | i_req_valid  | o_req_ready  | i_req  (op, center, scale, corner)
//  result    | o_rsp_valid  | i_rsp_ready  | o_rsp  (field, inside, count, sat)
//  config    | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// One request at a time. A splat with nonzero radius scans all NC^3 corners
// (NC = TILE_EDGE_CELLS+1, 729 at default), one corner per cycle, into the
// 25-stage kernel pipeline, which holds 16 restoring-divide stages and ends
// in a store read-modify-write. A clear sweeps the store one corner per cycle.
// A read fetches and captures the stored corner. After reset a clearing pass
// over all NC^3 corners runs before the first request is taken; config writes
// are accepted throughout. The result register frees the request side: a new
// request is taken while the previous result still waits on i_rsp_ready.
module metaball_field_splat #(
    parameter int TILE_EDGE_CELLS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  mfs_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output mfs_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import mfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns both handshakes
    mfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req_op   (i_req.op),
        .o_req_ready(o_req_ready),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: registers, kernel pipeline, field store, result register
    mfs_dp #(
        .TILE_EDGE_CELLS(TILE_EDGE_CELLS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (i_req),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_rsp     (o_rsp)
    );
endmodule
